/* rtl/qsw_pkg.sv */
// shared widths, types and constants for the quaternion placement matrix unit
package qsw_pkg;

  localparam int unsigned QW    = 16;  // quaternion component, Q1.14
  localparam int unsigned SW    = 16;  // uniform scale, unsigned Q8.8
  localparam int unsigned OW    = 32;  // origin and eye, Q24.8
  localparam int unsigned PW    = 33;  // 2ab in Q.28
  localparam int unsigned EW    = 35;  // unscaled entry in Q.28
  localparam int unsigned MW    = EW + SW + 1;  // scaled entry in Q.36
  localparam int unsigned RND_SH = 14;  // Q.36 down to Q.22
  localparam int unsigned QTW   = MW - RND_SH;  // rounded entry before saturation
  localparam int unsigned RW    = 32;  // matrix entry, Q.22
  localparam int unsigned TW    = 33;  // translation, Q24.8
  localparam int unsigned NENT  = 9;
  localparam int unsigned CIW   = 2;   // register index width

  typedef logic signed [PW-1:0]  prod_t;
  typedef logic signed [EW-1:0]  entry_t;
  typedef logic signed [MW-1:0]  mul_t;
  typedef logic signed [RW-1:0]  res_t;
  typedef logic signed [TW-1:0]  trans_t;
  typedef logic [CIW-1:0]        cfg_idx_t;

  // register indexes of the configuration port
  localparam cfg_idx_t CFG_EYE_X = 2'd0;
  localparam cfg_idx_t CFG_EYE_Y = 2'd1;
  localparam cfg_idx_t CFG_EYE_Z = 2'd2;

  localparam entry_t ONE_Q28  = entry_t'(64'sd268435456);
  localparam mul_t   RND_HALF = mul_t'(64'sd8192);
  localparam res_t   SAT_MAX  = 32'sh7fffffff;
  localparam res_t   SAT_MIN  = 32'sh80000000;

endpackage

/* rtl/quat_scale_to_world_matrix_unit.sv */
// scaled rotation plus translation from a quaternion placement, four-stage pipeline
//
// Each input transaction carries a quaternion (Q1.14), a uniform scale (Q8.8)
// and an origin (Q24.8); each output transaction carries the nine scaled
// rotation entries of the 3x4 world matrix in Q.22, saturated to 32 bits, and
// the translation origin minus eye in 33-bit Q24.8. Throughput is one
// transaction per cycle while out_ready does not stall the output; there is
// one register stage for each step: the nine 16x16 quaternion products,
// the entry sums, the 35x17 scale multiply and the round and saturate step.
// The eye offset registers eye_x, eye_y, eye_z (cfg_index 0..2, reset 0) are
// written through cfg_we; writes to index 3 are dropped. They are sampled in
// the first stage, so change them only while the pipeline is empty. Each
// stage holds its contents when the next one is full and stalled, so
// back-pressure on out_ready propagates to in_ready without losing data.
module quat_scale_to_world_matrix_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration write port
  input  logic                    cfg_we,
  input  logic [qsw_pkg::CIW-1:0] cfg_index,
  input  logic [qsw_pkg::OW-1:0]  cfg_wdata,
  // input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [qsw_pkg::QW-1:0] in_q_x,
  input  logic signed [qsw_pkg::QW-1:0] in_q_y,
  input  logic signed [qsw_pkg::QW-1:0] in_q_z,
  input  logic signed [qsw_pkg::QW-1:0] in_q_w,
  input  logic [qsw_pkg::SW-1:0]  in_uniform_scale,
  input  logic signed [qsw_pkg::OW-1:0] in_org_x,
  input  logic signed [qsw_pkg::OW-1:0] in_org_y,
  input  logic signed [qsw_pkg::OW-1:0] in_org_z,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [qsw_pkg::RW-1:0] out_m00,
  output logic signed [qsw_pkg::RW-1:0] out_m01,
  output logic signed [qsw_pkg::RW-1:0] out_m02,
  output logic signed [qsw_pkg::RW-1:0] out_m10,
  output logic signed [qsw_pkg::RW-1:0] out_m11,
  output logic signed [qsw_pkg::RW-1:0] out_m12,
  output logic signed [qsw_pkg::RW-1:0] out_m20,
  output logic signed [qsw_pkg::RW-1:0] out_m21,
  output logic signed [qsw_pkg::RW-1:0] out_m22,
  output logic signed [qsw_pkg::TW-1:0] out_t_x,
  output logic signed [qsw_pkg::TW-1:0] out_t_y,
  output logic signed [qsw_pkg::TW-1:0] out_t_z
);

  // eye offset registers
  logic signed [qsw_pkg::OW-1:0] eye_x_r, eye_y_r, eye_z_r;

  // stage valids and load enables
  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic en1, en2, en3, en4;

  // stage 1: doubled quaternion products, scale, translation
  qsw_pkg::prod_t xx_r, xy_r, xz_r, xw_r, yy_r, yz_r, yw_r, zz_r, zw_r;
  qsw_pkg::prod_t xx_nxt, xy_nxt, xz_nxt, xw_nxt, yy_nxt, yz_nxt, yw_nxt, zz_nxt, zw_nxt;
  logic [qsw_pkg::SW-1:0] s1_r, s2_r;
  qsw_pkg::trans_t t1_r [3];
  qsw_pkg::trans_t t2_r [3];
  qsw_pkg::trans_t t3_r [3];
  qsw_pkg::trans_t t4_r [3];
  qsw_pkg::trans_t t1_nxt [3];

  // stage 2: unscaled entries, stage 3: scaled entries, stage 4: results
  qsw_pkg::entry_t ent_r [qsw_pkg::NENT];
  qsw_pkg::entry_t ent_nxt [qsw_pkg::NENT];
  qsw_pkg::mul_t   mul_r [qsw_pkg::NENT];
  qsw_pkg::mul_t   mul_nxt [qsw_pkg::NENT];
  qsw_pkg::res_t   res_r [qsw_pkg::NENT];
  qsw_pkg::res_t   res_nxt [qsw_pkg::NENT];

  // sign extend a doubled product to entry width
  function automatic qsw_pkg::entry_t sx(input qsw_pkg::prod_t a);
    sx = {{(qsw_pkg::EW - qsw_pkg::PW){a[qsw_pkg::PW-1]}}, a};
  endfunction

  // 2ab from two Q1.14 components, exact in Q.28
  function automatic qsw_pkg::prod_t dbl_mul(input logic signed [qsw_pkg::QW-1:0] a,
                                             input logic signed [qsw_pkg::QW-1:0] b);
    logic signed [2*qsw_pkg::QW-1:0] m;
    m = a * b;
    dbl_mul = {m, 1'b0};
  endfunction

  // configuration writes; index 3 falls through and is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_x_r <= '0;
      eye_y_r <= '0;
      eye_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qsw_pkg::CFG_EYE_X: eye_x_r <= cfg_wdata;
        qsw_pkg::CFG_EYE_Y: eye_y_r <= cfg_wdata;
        qsw_pkg::CFG_EYE_Z: eye_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its contents move on this cycle
  assign en4 = !v4_r || out_ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;

  assign v1_nxt = en1 ? in_valid : v1_r;
  assign v2_nxt = en2 ? v1_r : v2_r;
  assign v3_nxt = en3 ? v2_r : v3_r;
  assign v4_nxt = en4 ? v3_r : v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // stage 1 logic: nine products and the exact 33-bit translation
  always_comb begin
    xx_nxt = dbl_mul(in_q_x, in_q_x);
    xy_nxt = dbl_mul(in_q_x, in_q_y);
    xz_nxt = dbl_mul(in_q_x, in_q_z);
    xw_nxt = dbl_mul(in_q_x, in_q_w);
    yy_nxt = dbl_mul(in_q_y, in_q_y);
    yz_nxt = dbl_mul(in_q_y, in_q_z);
    yw_nxt = dbl_mul(in_q_y, in_q_w);
    zz_nxt = dbl_mul(in_q_z, in_q_z);
    zw_nxt = dbl_mul(in_q_z, in_q_w);
    t1_nxt[0] = {in_org_x[qsw_pkg::OW-1], in_org_x} - {eye_x_r[qsw_pkg::OW-1], eye_x_r};
    t1_nxt[1] = {in_org_y[qsw_pkg::OW-1], in_org_y} - {eye_y_r[qsw_pkg::OW-1], eye_y_r};
    t1_nxt[2] = {in_org_z[qsw_pkg::OW-1], in_org_z} - {eye_z_r[qsw_pkg::OW-1], eye_z_r};
  end

  // stage 2 logic: the standard rotation form in Q.28
  always_comb begin
    ent_nxt[0] = qsw_pkg::ONE_Q28 - (sx(yy_r) + sx(zz_r));
    ent_nxt[1] = sx(xy_r) + sx(zw_r);
    ent_nxt[2] = sx(xz_r) - sx(yw_r);
    ent_nxt[3] = sx(xy_r) - sx(zw_r);
    ent_nxt[4] = qsw_pkg::ONE_Q28 - (sx(xx_r) + sx(zz_r));
    ent_nxt[5] = sx(yz_r) + sx(xw_r);
    ent_nxt[6] = sx(xz_r) + sx(yw_r);
    ent_nxt[7] = sx(yz_r) - sx(xw_r);
    ent_nxt[8] = qsw_pkg::ONE_Q28 - (sx(xx_r) + sx(yy_r));
  end

  // stage 3 logic: scale each entry, exact Q.36
  // stage 4 logic: round half up to Q.22 and saturate to 32 bits
  always_comb begin
    logic signed [qsw_pkg::SW:0] s_ext;
    qsw_pkg::mul_t rnd;
    logic signed [qsw_pkg::QTW-1:0] q;
    s_ext = {1'b0, s2_r};
    for (int i = 0; i < qsw_pkg::NENT; i++) begin
      mul_nxt[i] = ent_r[i] * s_ext;
    end
    for (int i = 0; i < qsw_pkg::NENT; i++) begin
      rnd = mul_r[i] + qsw_pkg::RND_HALF;
      q   = rnd[qsw_pkg::MW-1:qsw_pkg::RND_SH];
      if (q[qsw_pkg::QTW-1:qsw_pkg::RW-1] == '0 || q[qsw_pkg::QTW-1:qsw_pkg::RW-1] == '1) begin
        res_nxt[i] = q[qsw_pkg::RW-1:0];
      end else if (q[qsw_pkg::QTW-1]) begin
        res_nxt[i] = qsw_pkg::SAT_MIN;
      end else begin
        res_nxt[i] = qsw_pkg::SAT_MAX;
      end
    end
  end

  // datapath registers, loaded with their stage enables
  always_ff @(posedge clk) begin
    if (en1) begin
      xx_r <= xx_nxt;
      xy_r <= xy_nxt;
      xz_r <= xz_nxt;
      xw_r <= xw_nxt;
      yy_r <= yy_nxt;
      yz_r <= yz_nxt;
      yw_r <= yw_nxt;
      zz_r <= zz_nxt;
      zw_r <= zw_nxt;
      s1_r <= in_uniform_scale;
      for (int k = 0; k < 3; k++) t1_r[k] <= t1_nxt[k];
    end
    if (en2) begin
      for (int i = 0; i < qsw_pkg::NENT; i++) ent_r[i] <= ent_nxt[i];
      s2_r <= s1_r;
      for (int k = 0; k < 3; k++) t2_r[k] <= t1_r[k];
    end
    if (en3) begin
      for (int i = 0; i < qsw_pkg::NENT; i++) mul_r[i] <= mul_nxt[i];
      for (int k = 0; k < 3; k++) t3_r[k] <= t2_r[k];
    end
    if (en4) begin
      for (int i = 0; i < qsw_pkg::NENT; i++) res_r[i] <= res_nxt[i];
      for (int k = 0; k < 3; k++) t4_r[k] <= t3_r[k];
    end
  end

  // result channel
  assign out_valid = v4_r;
  assign out_m00 = res_r[0];
  assign out_m01 = res_r[1];
  assign out_m02 = res_r[2];
  assign out_m10 = res_r[3];
  assign out_m11 = res_r[4];
  assign out_m12 = res_r[5];
  assign out_m20 = res_r[6];
  assign out_m21 = res_r[7];
  assign out_m22 = res_r[8];
  assign out_t_x = t4_r[0];
  assign out_t_y = t4_r[1];
  assign out_t_z = t4_r[2];

`ifndef SYNTHESIS
  // back-pressure only ever starts at a stalled output
  a_ready_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without a stalled output");

  // an accepted transaction is held in stage 1 next cycle
  a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("accepted transaction not captured in stage 1");

  // a full stage that cannot move keeps its transaction
  a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !en4) |=> v3_r)
    else $error("stage 3 transaction dropped during stall");

  // a full stage 3 that moves fills the output register
  a_stage3_move: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && en4) |=> out_valid)
    else $error("stage 3 transaction lost on advance");
`endif

endmodule

/* bench/tb_quat_scale_to_world_matrix_unit.sv */
// self-checking bench for the quaternion placement to world matrix unit
`timescale 1ns / 100ps

module tb_quat_scale_to_world_matrix_unit;
  import qsw_pkg::*;

  // index 3 decodes to no register, writes there must be dropped
  localparam cfg_idx_t CFG_UNUSED = 2'd3;

  // 1.0 in the Q.28 domain of the unscaled entries, and half an lsb of Q.22 in Q.36
  localparam longint UNIT_Q28   = 64'sd1 << 28;
  localparam longint HALF_LSB   = 64'sd1 << (RND_SH - 1);
  localparam int     MAX_GAP    = 20;

  // one input transaction and one output transaction, as the bench sees them
  typedef struct packed {
    logic signed [QW-1:0] q_x;
    logic signed [QW-1:0] q_y;
    logic signed [QW-1:0] q_z;
    logic signed [QW-1:0] q_w;
    logic [SW-1:0]        uniform_scale;
    logic signed [OW-1:0] org_x;
    logic signed [OW-1:0] org_y;
    logic signed [OW-1:0] org_z;
  } placement_t;

  typedef struct packed {
    res_t   [NENT-1:0] m;  // row-major m00..m22
    trans_t [2:0]      t;  // x, y, z
  } world_matrix_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                 cfg_we;
  cfg_idx_t             cfg_index;
  logic [OW-1:0]        cfg_wdata;

  logic                 in_valid;
  logic                 in_ready;
  logic signed [QW-1:0] in_q_x, in_q_y, in_q_z, in_q_w;
  logic [SW-1:0]        in_uniform_scale;
  logic signed [OW-1:0] in_org_x, in_org_y, in_org_z;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  res_t                 out_m00, out_m01, out_m02;
  res_t                 out_m10, out_m11, out_m12;
  res_t                 out_m20, out_m21, out_m22;
  trans_t               out_t_x, out_t_y, out_t_z;

  // bench copy of the eye offset registers
  longint eye_x_off = 0;
  longint eye_y_off = 0;
  longint eye_z_off = 0;

  world_matrix_t expected_matrices[$];
  int            mismatch_count = 0;

  // idle odds in percent, set per phase by the test sequence
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // long output hold-off: the sequence bumps the id, the receiver counts it down
  int hold_stretch_len = 0;
  int hold_stretch_id  = 0;
  int hold_seen_id     = 0;
  int hold_left        = 0;

  quat_scale_to_world_matrix_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_q_x           (in_q_x),
    .in_q_y           (in_q_y),
    .in_q_z           (in_q_z),
    .in_q_w           (in_q_w),
    .in_uniform_scale (in_uniform_scale),
    .in_org_x         (in_org_x),
    .in_org_y         (in_org_y),
    .in_org_z         (in_org_z),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_m00          (out_m00),
    .out_m01          (out_m01),
    .out_m02          (out_m02),
    .out_m10          (out_m10),
    .out_m11          (out_m11),
    .out_m12          (out_m12),
    .out_m20          (out_m20),
    .out_m21          (out_m21),
    .out_m22          (out_m22),
    .out_t_x          (out_t_x),
    .out_t_y          (out_t_y),
    .out_t_z          (out_t_z)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // matrix predictor
  // ---------------------------------------------------------------------------

  // Q.28 entry times Q8.8 scale is exact Q.36; round half up to Q.22, then clamp
  function automatic res_t round_scaled_entry(input longint unscaled, input longint scale);
    longint q22;
    q22 = (unscaled * scale + HALF_LSB) >>> RND_SH;  // arithmetic shift floors
    if (q22 > 64'sd2147483647)
      return SAT_MAX;
    if (q22 < -64'sd2147483648)
      return SAT_MIN;
    return res_t'(q22);
  endfunction

  function automatic world_matrix_t predict_world_matrix(input placement_t p);
    world_matrix_t r;
    longint x, y, z, w, s;
    longint xx, xy, xz, xw, yy, yz, yw, zz, zw;
    x = $signed(p.q_x);
    y = $signed(p.q_y);
    z = $signed(p.q_z);
    w = $signed(p.q_w);
    s = p.uniform_scale;
    // doubled products of two Q1.14 values land directly in Q.28
    xx = 2 * x * x;
    xy = 2 * x * y;
    xz = 2 * x * z;
    xw = 2 * x * w;
    yy = 2 * y * y;
    yz = 2 * y * z;
    yw = 2 * y * w;
    zz = 2 * z * z;
    zw = 2 * z * w;
    r.m[0] = round_scaled_entry(UNIT_Q28 - (yy + zz), s);
    r.m[1] = round_scaled_entry(xy + zw, s);
    r.m[2] = round_scaled_entry(xz - yw, s);
    r.m[3] = round_scaled_entry(xy - zw, s);
    r.m[4] = round_scaled_entry(UNIT_Q28 - (xx + zz), s);
    r.m[5] = round_scaled_entry(yz + xw, s);
    r.m[6] = round_scaled_entry(xz + yw, s);
    r.m[7] = round_scaled_entry(yz - xw, s);
    r.m[8] = round_scaled_entry(UNIT_Q28 - (xx + yy), s);
    // 32-bit minus 32-bit always fits 33 bits, no clamp
    r.t[0] = trans_t'(longint'($signed(p.org_x)) - eye_x_off);
    r.t[1] = trans_t'(longint'($signed(p.org_y)) - eye_y_off);
    r.t[2] = trans_t'(longint'($signed(p.org_z)) - eye_z_off);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic placement_t make_placement(input int x, y, z, w, s,
                                                input logic [OW-1:0] ox, oy, oz);
    placement_t p;
    p.q_x           = x[QW-1:0];
    p.q_y           = y[QW-1:0];
    p.q_z           = z[QW-1:0];
    p.q_w           = w[QW-1:0];
    p.uniform_scale = s[SW-1:0];
    p.org_x         = ox;
    p.org_y         = oy;
    p.org_z         = oz;
    return p;
  endfunction

  function automatic logic [OW-1:0] random_origin();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // mostly unit quaternions, some in-range but unnormalized, some raw bit patterns
  function automatic placement_t random_placement();
    placement_t p;
    real    c0, c1, c2, c3, norm;
    int     kx, ky, kz, kw, ks, sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5) begin
      c0 = ($itor($urandom_range(0, 65535)) - 32768.0) / 32768.0;
      c1 = ($itor($urandom_range(0, 65535)) - 32768.0) / 32768.0;
      c2 = ($itor($urandom_range(0, 65535)) - 32768.0) / 32768.0;
      c3 = ($itor($urandom_range(0, 65535)) - 32768.0) / 32768.0;
      norm = c0 * c0 + c1 * c1 + c2 * c2 + c3 * c3;
      if (norm < 1.0e-6) begin
        c3   = 1.0;
        norm = 1.0;
      end
      norm = $sqrt(norm);
      kx = $rtoi(c0 / norm * 16384.0);
      ky = $rtoi(c1 / norm * 16384.0);
      kz = $rtoi(c2 / norm * 16384.0);
      kw = $rtoi(c3 / norm * 16384.0);
    end else if (sel <= 7) begin
      kx = int'($urandom_range(0, 32768)) - 16384;
      ky = int'($urandom_range(0, 32768)) - 16384;
      kz = int'($urandom_range(0, 32768)) - 16384;
      kw = int'($urandom_range(0, 32768)) - 16384;
    end else begin
      kx = $urandom;
      ky = $urandom;
      kz = $urandom;
      kw = $urandom;
    end
    case ($urandom_range(0, 7))
      0:       ks = 0;
      1:       ks = 65535;
      2:       ks = 256;
      default: ks = $urandom_range(0, 65535);
    endcase
    p = make_placement(kx, ky, kz, kw, ks, random_origin(), random_origin(), random_origin());
    return p;
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    mismatch_count++;
    $display("mismatch %s at %0t: expected %0d got %0d", what, $realtime, want, got);
  endtask

  // one register write per cycle; the caller lowers cfg_we after the last one
  task automatic write_register(input cfg_idx_t idx, input logic [OW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_EYE_X: eye_x_off = $signed(data);
      CFG_EYE_Y: eye_y_off = $signed(data);
      CFG_EYE_Z: eye_z_off = $signed(data);
      default: ;  // unmapped index, nothing changes
    endcase
  endtask

  // pipeline must be empty here: the unit samples the eye in its first stage
  task automatic write_eye_offsets(input logic [OW-1:0] ex, ey, ez);
    write_register(CFG_EYE_X, ex);
    write_register(CFG_EYE_Y, ey);
    write_register(CFG_EYE_Z, ez);
    write_register(CFG_UNUSED, $urandom);
    cfg_we <= 1'b0;
  endtask

  // in_valid stays high across back-to-back transactions so it never gets
  // two assignments in one step; it drops only ahead of a random gap
  task automatic send_placement(input placement_t p);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < MAX_GAP)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_q_x           <= p.q_x;
    in_q_y           <= p.q_y;
    in_q_z           <= p.q_z;
    in_q_w           <= p.q_w;
    in_uniform_scale <= p.uniform_scale;
    in_org_x         <= p.org_x;
    in_org_y         <= p.org_y;
    in_org_z         <= p.org_z;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    expected_matrices.push_back(predict_world_matrix(p));
  endtask

  // stop offering, wait for every pending result, then let the four stages empty
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (expected_matrices.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // eye registers come out of reset at zero, so translation equals origin
  task automatic test_reset_eye();
    send_placement(make_placement(0, 0, 0, 16384, 256,
                                  32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000));
    send_placement(make_placement(0, 0, 0, 16384, 256,
                                  32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff));
    wait_until_drained();
  endtask

  // field extremes, rounding ties, rotations and saturation of unnormalized input
  task automatic test_directed_corners();
    write_eye_offsets(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
    // identity at unit, zero, smallest and largest scale
    send_placement(make_placement(0, 0, 0, 16384, 256,
                                  32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000));
    send_placement(make_placement(0, 0, 0, 16384, 0,
                                  32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    send_placement(make_placement(0, 0, 0, 16384, 1, 0, 0, 0));
    send_placement(make_placement(0, 0, 0, 16384, 65535, 1, -1, 1));
    // negated scalar part describes the same rotation
    send_placement(make_placement(0, 0, 0, -16384, 256, 0, 0, 0));
    // quarter turns about x, y and z
    send_placement(make_placement(11585, 0, 0, 11585, 256, 0, 0, 0));
    send_placement(make_placement(0, 11585, 0, 11585, 384, 0, 0, 0));
    send_placement(make_placement(0, 0, 11585, -11585, 512, 0, 0, 0));
    // components at exactly plus and minus one: an unnormalized x,y pair and a half turn about z
    send_placement(make_placement(16384, -16384, 0, 0, 256, 0, 0, 0));
    send_placement(make_placement(0, 0, -16384, 0, 65535, 0, 0, 0));
    // unnormalized: entries far out of range, both saturation directions
    send_placement(make_placement(16384, 16384, 16384, 16384, 65535, 0, 0, 0));
    send_placement(make_placement(-32768, -32768, -32768, -32768, 65535, 0, 0, 0));
    send_placement(make_placement(32767, 32767, 32767, 32767, 65535, 0, 0, 0));
    send_placement(make_placement(32767, -32768, 32767, -32768, 65535, 0, 0, 0));
    // zero quaternion leaves only the diagonal at full scale
    send_placement(make_placement(0, 0, 0, 0, 65535, 0, 0, 0));
    // exact half-lsb ties on the off-diagonal, positive and negative, and just below
    send_placement(make_placement(1, 1, 0, 0, 4096, 0, 0, 0));
    send_placement(make_placement(1, -1, 0, 0, 4096, 0, 0, 0));
    send_placement(make_placement(1, 1, 0, 0, 4095, 0, 0, 0));
    wait_until_drained();
    // opposite eye extremes, widest translation both ways
    write_eye_offsets(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_placement(make_placement(0, 0, 0, 16384, 256,
                                  32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send_placement(make_placement(0, 0, 0, 16384, 256,
                                  32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
    wait_until_drained();
  endtask

  task automatic test_random_stream(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_eye_offsets($urandom, $urandom, $urandom);
    repeat (count)
      send_placement(random_placement());
    wait_until_drained();
  endtask

  // receiver stalls for a long stretch while the sender keeps offering,
  // so all four stages fill and in_ready must drop without losing anything
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_eye_offsets(32'h0000_0000, $urandom, 32'h7fff_ffff);
    hold_stretch_len = 120;
    hold_stretch_id++;
    repeat (40)
      send_placement(random_placement());
    wait_until_drained();
  endtask

  // ---------------------------------------------------------------------------
  // receiver side
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_stretch_id != hold_seen_id) begin
      hold_seen_id <= hold_stretch_id;
      hold_left    <= hold_stretch_len;
      out_ready    <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // every accepted output transaction is checked against the oldest prediction
  always @(posedge clk) begin : result_check
    world_matrix_t got_matrix;
    world_matrix_t want_matrix;
    if (rst_n && out_valid && out_ready) begin
      got_matrix.m[0] = out_m00;
      got_matrix.m[1] = out_m01;
      got_matrix.m[2] = out_m02;
      got_matrix.m[3] = out_m10;
      got_matrix.m[4] = out_m11;
      got_matrix.m[5] = out_m12;
      got_matrix.m[6] = out_m20;
      got_matrix.m[7] = out_m21;
      got_matrix.m[8] = out_m22;
      got_matrix.t[0] = out_t_x;
      got_matrix.t[1] = out_t_y;
      got_matrix.t[2] = out_t_z;
      if (expected_matrices.size() == 0) begin
        report_mismatch("result with nothing pending", 0, 0);
      end else begin
        want_matrix = expected_matrices.pop_front();
        for (int i = 0; i < NENT; i++) begin
          if (got_matrix.m[i] !== want_matrix.m[i])
            report_mismatch($sformatf("m%0d%0d", i / 3, i % 3),
                            longint'($signed(want_matrix.m[i])),
                            longint'($signed(got_matrix.m[i])));
        end
        for (int i = 0; i < 3; i++) begin
          if (got_matrix.t[i] !== want_matrix.t[i])
            report_mismatch($sformatf("t_%s", (i == 0) ? "x" : (i == 1) ? "y" : "z"),
                            longint'($signed(want_matrix.t[i])),
                            longint'($signed(got_matrix.t[i])));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_EYE_X;
    cfg_wdata        = '0;
    in_valid         = 1'b0;
    in_q_x           = '0;
    in_q_y           = '0;
    in_q_z           = '0;
    in_q_w           = '0;
    in_uniform_scale = '0;
    in_org_x         = '0;
    in_org_y         = '0;
    in_org_z         = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_eye();
    test_directed_corners();
    test_random_stream(400, 30, 63);  // slow receiver
    test_random_stream(400, 63, 30);  // slow sender
    test_random_stream(300, 0, 0);    // full rate
    test_output_hold_off();

    if (mismatch_count == 0 && expected_matrices.size() == 0)
      $display("quat_scale_to_world_matrix_unit regression: pass");
    else
      $display("quat_scale_to_world_matrix_unit regression: fail");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("quat_scale_to_world_matrix_unit regression: fail");
    $finish;
  end

endmodule
